// File: src/pbew_pkg.sv
// pbew_pkg: shared types and constants of the pci bus enumeration walker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pbew_pkg;

  // result kinds
  localparam logic [1:0] KIND_PROBE = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // input opcodes
  localparam logic OP_START    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // configuration register indexes
  localparam logic CFG_CLASS_FILTER    = 1'b0;
  localparam logic CFG_SUBCLASS_FILTER = 1'b1;

  // filter value that matches anything (-1 in 9 bits)
  localparam logic [8:0] FILTER_ANY = 9'h1FF;

  // config space codes
  localparam logic [7:0]  ABSENT_CLASS   = 8'hFF;
  localparam logic [15:0] ABSENT_VENDOR  = 16'hFFFF;
  localparam logic [7:0]  BRIDGE_CLASS   = 8'h06;
  localparam logic [7:0]  P2P_SUBCLASS   = 8'h04;
  localparam int          MULTI_FUNC_BIT = 7;
  localparam logic [4:0]  LAST_SLOT      = 5'd31;
  localparam logic [2:0]  LAST_FUNC      = 3'd7;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_bus;
    logic [4:0] out_slot;
    logic [2:0] out_func;
    logic       bridge_dropped;
    logic       last_result;
  } res_t;

endpackage
`default_nettype wire

// File: src/pbew_if.sv
// pbew_if: channel interfaces of the walker (request, result, config write)
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface pbew_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] vendor_id;
  logic [7:0]  device_class;
  logic [7:0]  device_subclass;
  logic [7:0]  header_type_in;
  logic [7:0]  sec_bus;

  modport source (output valid, opcode, vendor_id, device_class, device_subclass,
                  header_type_in, sec_bus, input ready);
  modport sink (input valid, opcode, vendor_id, device_class, device_subclass,
                header_type_in, sec_bus, output ready);
endinterface

interface pbew_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_bus;
  logic [4:0] out_slot;
  logic [2:0] out_func;
  logic       bridge_dropped;
  logic       last_result;

  modport source (output valid, result_kind, out_bus, out_slot, out_func,
                  bridge_dropped, last_result, input ready);
  modport sink (input valid, result_kind, out_bus, out_slot, out_func,
                bridge_dropped, last_result, output ready);
endinterface

interface pbew_cfg_if;
  logic       valid;
  logic       ready;
  logic       addr;
  logic [8:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// File: src/pci_bus_enumeration_walker_core.sv
// pci_bus_enumeration_walker_core: top level of the pci config space walker
// depends on pbew_pkg, pbew_if and pbew_res_fifo
`timescale 1ns / 1ps
`default_nettype none
// The walker steps through pci configuration space one function at a time.
// A start item (opcode 0) restarts at bus 0, slot 0, function 0 and gives one
// probe result. Each response item (opcode 1) reports what was read at the
// last probe and gives a found result when the function matches the class and
// subclass filters, followed by either the next probe or, once all slots are
// walked and no bridge is left on the stack, a done result. Responses while
// idle are taken and dropped. Present pci-to-pci bridges push their secondary
// bus onto a STACK_DEPTH-deep lifo held in a memory; a bridge found with the
// stack full is dropped and flagged on every result of that item.
// Each item is handled in the cycle it is accepted: the state registers and
// a four-entry result queue are written at that edge, so one item can be
// taken every cycle. The queue drains one result per cycle while out.ready
// is high; input stalls only while the queue holds more than two results (an
// item with a found result writes two). The stack memory needs no clearing
// pass after reset; its top entry is prefetched into a register every cycle.
// Config writes are always accepted and take effect on the next response.
module pci_bus_enumeration_walker_core #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pbew_cfg_if.sink   cfg,
  pbew_req_if.sink   in,
  pbew_res_if.source out
);

  // count holds 0..STACK_DEPTH, address covers 0..STACK_DEPTH-1
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // filter registers
  logic [8:0] class_filter;
  logic [8:0] subclass_filter;

  // walk state
  logic [7:0]    cur_bus;
  logic [4:0]    cur_slot;
  logic [2:0]    cur_func;
  logic [7:0]    header_byte;
  logic [CW-1:0] stack_count;
  logic          walking;

  logic [7:0]    cur_bus_next;
  logic [4:0]    cur_slot_next;
  logic [2:0]    cur_func_next;
  logic [7:0]    header_byte_next;
  logic [CW-1:0] stack_count_next;
  logic          walking_next;

  // bridge stack and its prefetched top entry
  logic [7:0]    bridge_stack [STACK_DEPTH];
  logic [7:0]    stack_top;

  logic          accept;
  logic          respond;
  logic [7:0]    hdr_eff;
  logic          present;
  logic          is_bridge;
  logic          push;
  logic          pop;
  logic          dropped;
  logic          match;
  logic          class_ok;
  logic          subclass_ok;
  logic [CW-1:0] count_pushed;
  logic [CW-1:0] rd_index;

  logic           wr_a;
  logic           wr_b;
  pbew_pkg::res_t res_a;
  pbew_pkg::res_t res_b;
  logic           room_for_two;

  assign cfg.ready = 1'b1;
  assign in.ready  = room_for_two;
  assign accept    = in.valid && in.ready;
  assign respond   = accept && (in.opcode == pbew_pkg::OP_RESPONSE) && walking;

  // -1 matches all, any other negative value matches nothing
  function automatic logic filter_hit(input logic [8:0] f, input logic [7:0] v);
    filter_hit = (f == pbew_pkg::FILTER_ANY) || (!f[8] && (f[7:0] == v));
  endfunction

  // header type of function 0 gates functions 1 to 7; on function 0 the byte
  // just read counts, even the all-ones value of an absent function
  assign hdr_eff = (cur_func == 3'd0) ? in.header_type_in : header_byte;

  assign present   = !((in.device_class == pbew_pkg::ABSENT_CLASS) &&
                       (in.vendor_id == pbew_pkg::ABSENT_VENDOR));
  assign is_bridge = present && (in.device_class == pbew_pkg::BRIDGE_CLASS) &&
                     (in.device_subclass == pbew_pkg::P2P_SUBCLASS);
  assign push      = is_bridge && (stack_count < CW'(STACK_DEPTH));
  assign dropped   = is_bridge && !push;

  assign class_ok    = filter_hit(class_filter, in.device_class);
  assign subclass_ok = filter_hit(subclass_filter, in.device_subclass);
  assign match       = present && class_ok && subclass_ok;

  assign count_pushed = stack_count + {{(CW-1){1'b0}}, push};

  // next probe position, stack update and results
  always_comb begin
    cur_bus_next     = cur_bus;
    cur_slot_next    = cur_slot;
    cur_func_next    = cur_func;
    header_byte_next = header_byte;
    stack_count_next = stack_count;
    walking_next     = walking;
    pop              = 1'b0;
    wr_a             = 1'b0;
    wr_b             = 1'b0;
    res_a            = '0;
    res_b            = '0;

    if (accept && (in.opcode == pbew_pkg::OP_START)) begin
      cur_bus_next      = '0;
      cur_slot_next     = '0;
      cur_func_next     = '0;
      header_byte_next  = '0;
      stack_count_next  = '0;
      walking_next      = 1'b1;
      wr_a              = 1'b1;
      res_a.result_kind = pbew_pkg::KIND_PROBE;
      res_a.last_result = 1'b1;
    end else if (respond) begin
      header_byte_next = hdr_eff;
      stack_count_next = count_pushed;
      if (hdr_eff[pbew_pkg::MULTI_FUNC_BIT] && (cur_func != pbew_pkg::LAST_FUNC)) begin
        cur_func_next = cur_func + 3'd1;
      end else begin
        cur_func_next = '0;
        if (cur_slot != pbew_pkg::LAST_SLOT) begin
          cur_slot_next = cur_slot + 5'd1;
        end else begin
          cur_slot_next = '0;
          if (count_pushed != '0) begin
            // a bridge pushed by this very item is popped straight back
            pop              = 1'b1;
            stack_count_next = count_pushed - {{(CW-1){1'b0}}, 1'b1};
            cur_bus_next     = push ? in.sec_bus : stack_top;
          end else begin
            walking_next = 1'b0;
          end
        end
      end

      // final result: next probe, or done with a zero address
      res_b.result_kind    = walking_next ? pbew_pkg::KIND_PROBE : pbew_pkg::KIND_DONE;
      res_b.out_bus        = walking_next ? cur_bus_next : 8'd0;
      res_b.out_slot       = walking_next ? cur_slot_next : 5'd0;
      res_b.out_func       = walking_next ? cur_func_next : 3'd0;
      res_b.bridge_dropped = dropped;
      res_b.last_result    = 1'b1;

      if (match) begin
        wr_a                 = 1'b1;
        wr_b                 = 1'b1;
        res_a.result_kind    = pbew_pkg::KIND_FOUND;
        res_a.out_bus        = cur_bus;
        res_a.out_slot       = cur_slot;
        res_a.out_func       = cur_func;
        res_a.bridge_dropped = dropped;
        res_a.last_result    = 1'b0;
      end else begin
        wr_a  = 1'b1;
        res_a = res_b;
      end
    end
  end

  // top entry after this edge sits at stack_count_next - 1
  assign rd_index = stack_count_next - {{(CW-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (respond && push) begin
      bridge_stack[stack_count[AW-1:0]] <= in.sec_bus;
    end
    // forward the entry being pushed when it becomes the new top
    if (respond && push && !pop) begin
      stack_top <= in.sec_bus;
    end else begin
      stack_top <= bridge_stack[rd_index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_filter    <= pbew_pkg::FILTER_ANY;
      subclass_filter <= pbew_pkg::FILTER_ANY;
      cur_bus         <= '0;
      cur_slot        <= '0;
      cur_func        <= '0;
      header_byte     <= '0;
      stack_count     <= '0;
      walking         <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          pbew_pkg::CFG_CLASS_FILTER:    class_filter    <= cfg.data;
          pbew_pkg::CFG_SUBCLASS_FILTER: subclass_filter <= cfg.data;
          default: ;
        endcase
      end
      cur_bus     <= cur_bus_next;
      cur_slot    <= cur_slot_next;
      cur_func    <= cur_func_next;
      header_byte <= header_byte_next;
      stack_count <= stack_count_next;
      walking     <= walking_next;
    end
  end

  pbew_res_fifo u_res_fifo (
    .clk          (clk),
    .rst          (rst),
    .wr_a         (wr_a),
    .wr_b         (wr_b),
    .data_a       (res_a),
    .data_b       (res_b),
    .room_for_two (room_for_two),
    .out          (out)
  );

endmodule
`default_nettype wire

// File: src/pbew_res_fifo.sv
// pbew_res_fifo: four-entry result queue, takes up to two results a cycle
// depends on pbew_pkg (res_t) and pbew_if (pbew_res_if)
`timescale 1ns / 1ps
`default_nettype none
module pbew_res_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_a,
  input  wire logic           wr_b,
  input  wire pbew_pkg::res_t data_a,
  input  wire pbew_pkg::res_t data_b,
  output logic                room_for_two,
  pbew_res_if.source          out
);

  pbew_pkg::res_t entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;
  logic [2:0] n_wr;

  assign pop          = out.valid && out.ready;
  assign n_wr         = {2'b00, wr_a} + {2'b00, wr_b};
  assign room_for_two = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      // b is only ever written together with a
      if (wr_a) begin
        entries[wr_ptr] <= data_a;
      end
      if (wr_b) begin
        entries[wr_ptr + 2'd1] <= data_b;
      end
      wr_ptr <= wr_ptr + n_wr[1:0];
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + n_wr - {2'b00, pop};
    end
  end

  assign out.valid          = (count != 3'd0);
  assign out.result_kind    = entries[rd_ptr].result_kind;
  assign out.out_bus        = entries[rd_ptr].out_bus;
  assign out.out_slot       = entries[rd_ptr].out_slot;
  assign out.out_func       = entries[rd_ptr].out_func;
  assign out.bridge_dropped = entries[rd_ptr].bridge_dropped;
  assign out.last_result    = entries[rd_ptr].last_result;

endmodule
`default_nettype wire
